// File: rtl/gfp_pkg.sv
// Shared constants and controller/datapath interface types for the Gray bit-field packer.
`default_nettype none
package gfp_pkg;

  localparam int FRAME_BYTES     = 64;
  localparam int MAX_FIELD_WIDTH = 16;
  localparam int ADDR_W          = $clog2(FRAME_BYTES);
  localparam int POS_W           = $clog2(FRAME_BYTES * 8);
  localparam int FW_W            = 5;
  localparam int KIND_W          = 3;
  localparam int BYTE_W          = 8;
  // A field of up to 16 bits at any bit offset within a byte spans at most three bytes.
  localparam int WIN_BYTES       = 3;
  localparam int WIN_W           = WIN_BYTES * BYTE_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PACK   = 3'd0,
    KIND_UNPACK = 3'd1,
    KIND_SETPOS = 3'd2,
    KIND_WRBYTE = 3'd3,
    KIND_RDBYTE = 3'd4
  } kind_e;

  typedef struct packed {
    logic       load;    // capture the incoming item
    logic       rd_en;   // issue a frame store read
    logic [1:0] rd_idx;  // window byte to read
    logic       rd_abs;  // read at the item's byte address instead
    logic       proc;    // consume a returned window byte
    logic       wr_byte; // whole-byte write
    logic       cap;     // capture a returned byte as the result
    logic       fin;     // load the output register and update the cursor
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] in_kind;
    logic              in_zero_w;
    logic              out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/gfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module gfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/gfp_datapath.sv
// Datapath: item registers, bit cursor, frame store with valid bits, field coding, output register.
`default_nettype none
module gfp_datapath
  import gfp_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cmd_t                       cmd_i,
  output sts_t                            sts_o,
  input  wire logic [KIND_W-1:0]          kind_i,
  input  wire logic [MAX_FIELD_WIDTH-1:0] field_value_i,
  input  wire logic [FW_W-1:0]            field_width_i,
  input  wire logic [ADDR_W-1:0]          byte_address_i,
  input  wire logic [BYTE_W-1:0]          byte_data_i,
  input  wire logic [POS_W-1:0]           new_bit_position_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [MAX_FIELD_WIDTH-1:0] read_value_o,
  output logic      [POS_W-1:0]           bit_position_o
);

  localparam int SH_W = $clog2(WIN_W);

  logic [KIND_W-1:0]          kind_q;
  logic [MAX_FIELD_WIDTH-1:0] val_q;
  logic [FW_W-1:0]            w_q;
  logic [ADDR_W-1:0]          addr_q;
  logic [BYTE_W-1:0]          data_q;
  logic [POS_W-1:0]           npos_q;
  logic [POS_W-1:0]           cur_q, cur_d;
  logic [WIN_W-1:0]           acc_q;
  logic [1:0]                 pcnt_q;
  logic [ADDR_W-1:0]          last_addr_q;
  logic                       rvld_q;
  logic [FRAME_BYTES-1:0]     vld_q;
  logic [BYTE_W-1:0]          res_byte_q;
  logic                       out_valid_q;
  logic [MAX_FIELD_WIDTH-1:0] out_rv_q;
  logic [POS_W-1:0]           out_pos_q;

  logic [FW_W-1:0]            in_w;
  logic [ADDR_W-1:0]          b0_addr, rd_addr, wr_addr;
  logic [BYTE_W-1:0]          rdata, rbyte, wdata, win_byte;
  logic                       we;
  logic [MAX_FIELD_WIDTH:0]   mask_wide;
  logic [MAX_FIELD_WIDTH-1:0] mask, gray_f, dec_f, result;
  logic [SH_W-1:0]            win_sh;
  logic [WIN_W-1:0]           win, unp_win;
  logic                       is_field;

  function automatic logic [MAX_FIELD_WIDTH-1:0] gray_decode(
    input logic [MAX_FIELD_WIDTH-1:0] g
  );
    logic [MAX_FIELD_WIDTH-1:0] t;
    t = g ^ (g >> 8);
    t = t ^ (t >> 4);
    t = t ^ (t >> 2);
    t = t ^ (t >> 1);
    return t;
  endfunction

  // Widths above the maximum saturate.
  assign in_w = (field_width_i > FW_W'(MAX_FIELD_WIDTH)) ? FW_W'(MAX_FIELD_WIDTH)
                                                          : field_width_i;

  assign sts_o.in_kind   = kind_i;
  assign sts_o.in_zero_w = (field_width_i == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign b0_addr  = cur_q[POS_W-1:3];
  assign rd_addr  = cmd_i.rd_abs ? addr_q : ADDR_W'(b0_addr + ADDR_W'(cmd_i.rd_idx));
  assign rbyte    = rvld_q ? rdata : '0;

  // Field placed MSB-first in a three-byte window starting at the cursor's byte.
  assign mask_wide = ((MAX_FIELD_WIDTH+1)'(1) << w_q) - (MAX_FIELD_WIDTH+1)'(1);
  assign mask      = mask_wide[MAX_FIELD_WIDTH-1:0];
  assign gray_f    = (val_q & mask) ^ ((val_q & mask) >> 1);
  assign win_sh    = SH_W'(WIN_W) - SH_W'(cur_q[2:0]) - SH_W'(w_q);
  assign win       = WIN_W'(gray_f) << win_sh;
  assign unp_win   = acc_q >> win_sh;
  assign dec_f     = gray_decode(unp_win[MAX_FIELD_WIDTH-1:0] & mask);
  assign is_field  = (kind_q == KIND_PACK) || (kind_q == KIND_UNPACK);

  always_comb begin
    unique case (pcnt_q)
      2'd0:    win_byte = win[WIN_W-1 -: BYTE_W];
      2'd1:    win_byte = win[WIN_W-BYTE_W-1 -: BYTE_W];
      default: win_byte = win[BYTE_W-1:0];
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = last_addr_q;
    wdata   = rbyte | win_byte;
    if (cmd_i.wr_byte) begin
      we      = 1'b1;
      wr_addr = addr_q;
      wdata   = data_q;
    end else if (cmd_i.proc && (kind_q == KIND_PACK)) begin
      we = 1'b1;
    end
  end

  always_comb begin
    result = '0;
    cur_d  = cur_q;
    if (kind_q == KIND_UNPACK && w_q != '0) begin
      result = dec_f;
    end else if (kind_q == KIND_RDBYTE) begin
      result = MAX_FIELD_WIDTH'(res_byte_q);
    end
    if (is_field) begin
      cur_d = POS_W'(cur_q + POS_W'(w_q));
    end else if (kind_q == KIND_SETPOS) begin
      cur_d = npos_q;
    end
  end

  gfp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_addr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // Item payload and window registers need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      val_q  <= field_value_i;
      w_q    <= in_w;
      addr_q <= byte_address_i;
      data_q <= byte_data_i;
      npos_q <= new_bit_position_i;
      pcnt_q <= '0;
    end
    if (cmd_i.rd_en) begin
      last_addr_q <= rd_addr;
    end
    if (cmd_i.proc) begin
      acc_q  <= {acc_q[WIN_W-BYTE_W-1:0], rbyte};
      pcnt_q <= pcnt_q + 2'd1;
    end
    if (cmd_i.cap) begin
      res_byte_q <= rbyte;
    end
    if (cmd_i.fin) begin
      out_rv_q  <= result;
      out_pos_q <= cur_d;
    end
  end

  // Bytes never written read as zero, as after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        rvld_q <= vld_q[rd_addr];
      end
      if (we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.fin) begin
        cur_q       <= cur_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = out_rv_q;
  assign bit_position_o = out_pos_q;

endmodule
`default_nettype wire

// File: rtl/gfp_ctrl.sv
// Controller state machine sequencing the frame store accesses of each item.
`default_nettype none
module gfp_ctrl
  import gfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_F0   = 9'b000000010,
    S_F1   = 9'b000000100,
    S_F2   = 9'b000001000,
    S_F3   = 9'b000010000,
    S_WR   = 9'b000100000,
    S_RD   = 9'b001000000,
    S_RC   = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          priority if ((sts_i.in_kind == KIND_PACK || sts_i.in_kind == KIND_UNPACK)
                       && !sts_i.in_zero_w) begin
            state_d = S_F0;
          end else if (sts_i.in_kind == KIND_WRBYTE) begin
            state_d = S_WR;
          end else if (sts_i.in_kind == KIND_RDBYTE) begin
            state_d = S_RD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      // Reads of the next window byte overlap with the update of the previous one.
      S_F0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_idx = 2'd0;
        state_d      = S_F1;
      end
      S_F1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_idx = 2'd1;
        cmd_o.proc   = 1'b1;
        state_d      = S_F2;
      end
      S_F2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_idx = 2'd2;
        cmd_o.proc   = 1'b1;
        state_d      = S_F3;
      end
      S_F3: begin
        cmd_o.proc = 1'b1;
        state_d    = S_FIN;
      end
      S_WR: begin
        cmd_o.wr_byte = 1'b1;
        state_d       = S_FIN;
      end
      S_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_abs = 1'b1;
        state_d      = S_RC;
      end
      S_RC: begin
        cmd_o.cap = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/gray_bit_field_packer.sv
// Top level of the Gray-coded bit-field packer and unpacker over a 64-byte frame store.
//
// Input channel (in_valid_i / in_ready_o) carries one item per transfer: pack a field,
// unpack a field, set the bit position, write a byte or read a byte. Each item yields
// exactly one result transfer on the output channel (out_valid_o / out_ready_i) with
// the read value and the bit position after the item.
// Items are handled one at a time. A pack or unpack of nonzero width makes three byte reads
// of the frame store through its single read and single write port; a pack overlaps them with
// the read-modify-write of each byte. The next item is taken in the cycle after a result
// is loaded.
// A finished result sits in the output register, so the next item is taken while it
// waits; a stalled receiver holds the block only once the next result is ready.
// Reset clears the bit position, the output valid flag and the per-byte valid bits, so
// the whole frame store reads as zero right after reset without a clearing pass.
`default_nettype none
module gray_bit_field_packer
  import gfp_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [KIND_W-1:0]          kind_i,
  input  wire logic [MAX_FIELD_WIDTH-1:0] field_value_i,
  input  wire logic [FW_W-1:0]            field_width_i,
  input  wire logic [ADDR_W-1:0]          byte_address_i,
  input  wire logic [BYTE_W-1:0]          byte_data_i,
  input  wire logic [POS_W-1:0]           new_bit_position_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [MAX_FIELD_WIDTH-1:0] read_value_o,
  output logic      [POS_W-1:0]           bit_position_o
);

  cmd_t cmd;
  sts_t sts;

  gfp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gfp_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (kind_i),
    .field_value_i     (field_value_i),
    .field_width_i     (field_width_i),
    .byte_address_i    (byte_address_i),
    .byte_data_i       (byte_data_i),
    .new_bit_position_i(new_bit_position_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_value_o      (read_value_o),
    .bit_position_o    (bit_position_o)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the Gray-coded bit-field packer and its frame store.
`timescale 1ns / 100ps

module testbench
  import gfp_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 1850;
  localparam int MAX_REPORTS = 10;
  localparam int STORE_BITS  = FRAME_BYTES * 8;
  localparam logic [KIND_W-1:0] KIND_LAST = '1;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [MAX_FIELD_WIDTH-1:0] value;
    logic [FW_W-1:0]            width;
    logic [ADDR_W-1:0]          addr;
    logic [BYTE_W-1:0]          data;
    logic [POS_W-1:0]           pos;
  } packer_item_t;

  typedef struct packed {
    logic [MAX_FIELD_WIDTH-1:0] read_value;
    logic [POS_W-1:0]           bit_position;
  } packer_result_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid      = 1'b0;
  logic [KIND_W-1:0]          kind_in       = '0;
  logic [MAX_FIELD_WIDTH-1:0] field_value   = '0;
  logic [FW_W-1:0]            field_width   = '0;
  logic [ADDR_W-1:0]          byte_address  = '0;
  logic [BYTE_W-1:0]          byte_data     = '0;
  logic [POS_W-1:0]           new_position  = '0;
  logic                       out_ready     = 1'b0;

  logic                       in_ready_o;
  logic                       out_valid_o;
  logic [MAX_FIELD_WIDTH-1:0] read_value_o;
  logic [POS_W-1:0]           bit_position_o;

  // Image of the frame store and cursor, updated as each transfer is accepted.
  logic [BYTE_W-1:0] store_image [FRAME_BYTES];
  logic [POS_W-1:0]  cursor_image;

  packer_result_t pending_results[$];
  int  items_sent = 0;
  int  mismatches = 0;
  int  cycles     = 0;
  bit  quiet      = 1'b0;

  gray_bit_field_packer DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_in),
    .field_value_i     (field_value),
    .field_width_i     (field_width),
    .byte_address_i    (byte_address),
    .byte_data_i       (byte_data),
    .new_bit_position_i(new_position),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .read_value_o      (read_value_o),
    .bit_position_o    (bit_position_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int effective_width(input logic [FW_W-1:0] w);
    return (w > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : int'(w);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FW_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) return FW_W'($urandom_range(1, MAX_FIELD_WIDTH));
    if (r < 90) return '0;
    return FW_W'($urandom_range(MAX_FIELD_WIDTH + 1, (1 << FW_W) - 1));
  endfunction

  // Computes the result of one item and advances the store and cursor image.
  function automatic packer_result_t apply_item(input packer_item_t it);
    packer_result_t res;
    logic [31:0] f;
    logic [MAX_FIELD_WIDTH-1:0] decoded;
    logic acc;
    int w;
    int i;
    res = '0;
    w = effective_width(it.width);
    case (it.kind)
      KIND_PACK: if (w != 0) begin
        f = 32'(it.value) & ((32'd1 << w) - 32'd1);
        if (w > 1) f = f ^ (f >> 1);
        for (i = w - 1; i >= 0; i--) begin
          if (f[i]) store_image[cursor_image[POS_W-1:3]][3'd7 - cursor_image[2:0]] = 1'b1;
          cursor_image = cursor_image + 1'b1;
        end
      end
      KIND_UNPACK: if (w != 0) begin
        f = '0;
        for (i = 0; i < w; i++) begin
          f = (f << 1) | 32'(store_image[cursor_image[POS_W-1:3]][3'd7 - cursor_image[2:0]]);
          cursor_image = cursor_image + 1'b1;
        end
        if (w > 1) begin
          // Each decoded bit is the XOR of all code bits at and above it.
          acc = 1'b0;
          for (i = MAX_FIELD_WIDTH - 1; i >= 0; i--) begin
            acc = acc ^ f[i];
            decoded[i] = acc;
          end
          res.read_value = decoded;
        end else begin
          res.read_value = f[MAX_FIELD_WIDTH-1:0];
        end
      end
      KIND_SETPOS: cursor_image = POS_W'(int'(it.pos) % STORE_BITS);
      KIND_WRBYTE: store_image[it.addr] = it.data;
      KIND_RDBYTE: res.read_value = MAX_FIELD_WIDTH'(store_image[it.addr]);
      default: ;
    endcase
    res.bit_position = cursor_image;
    return res;
  endfunction

  function automatic packer_item_t random_item(input logic [KIND_W-1:0] kind);
    packer_item_t it;
    it.kind  = kind;
    it.value = MAX_FIELD_WIDTH'($urandom);
    it.width = FW_W'($urandom);
    it.addr  = ADDR_W'($urandom);
    it.data  = BYTE_W'($urandom);
    it.pos   = POS_W'($urandom);
    return it;
  endfunction

  task automatic send_item(input packer_item_t it);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    kind_in      <= it.kind;
    field_value  <= it.value;
    field_width  <= it.width;
    byte_address <= it.addr;
    byte_data    <= it.data;
    new_position <= it.pos;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_item(it));
    items_sent++;
  endtask

  task automatic pack_field(input logic [FW_W-1:0] w, input logic [MAX_FIELD_WIDTH-1:0] v);
    packer_item_t it;
    it = random_item(KIND_PACK);
    it.width = w;
    it.value = v;
    send_item(it);
  endtask

  task automatic unpack_field(input logic [FW_W-1:0] w);
    packer_item_t it;
    it = random_item(KIND_UNPACK);
    it.width = w;
    send_item(it);
  endtask

  task automatic set_position(input logic [POS_W-1:0] p);
    packer_item_t it;
    it = random_item(KIND_SETPOS);
    it.pos = p;
    send_item(it);
  endtask

  task automatic write_byte(input logic [ADDR_W-1:0] a, input logic [BYTE_W-1:0] d);
    packer_item_t it;
    it = random_item(KIND_WRBYTE);
    it.addr = a;
    it.data = d;
    send_item(it);
  endtask

  task automatic read_byte(input logic [ADDR_W-1:0] a);
    packer_item_t it;
    it = random_item(KIND_RDBYTE);
    it.addr = a;
    send_item(it);
  endtask

  task automatic test_byte_access();
    logic [KIND_W-1:0] k;
    write_byte('0, '1);
    write_byte('1, 8'h81);
    read_byte('0);
    read_byte('1);
    read_byte(ADDR_W'(17));
    // Kinds above the last defined one must leave everything alone.
    for (k = KIND_RDBYTE + 1'b1; k != '0; k++) send_item(random_item(k));
  endtask

  task automatic test_field_extremes();
    write_byte('0, '0);
    set_position('0);
    pack_field(FW_W'(MAX_FIELD_WIDTH), '1);
    pack_field(FW_W'(1), 16'h0001);
    pack_field('0, '1);
    pack_field('1, 16'h8001);
    set_position('0);
    unpack_field(FW_W'(MAX_FIELD_WIDTH));
    unpack_field(FW_W'(1));
    unpack_field('0);
    unpack_field('1);
    // A field that runs off the end of the store wraps to bit zero.
    set_position('1);
    pack_field(FW_W'(MAX_FIELD_WIDTH), 16'h1234);
    set_position('1);
    unpack_field(FW_W'(MAX_FIELD_WIDTH));
  endtask

  task automatic run_roundtrip();
    logic [FW_W-1:0]   widths [4];
    logic [POS_W-1:0]  start;
    logic [ADDR_W-1:0] a;
    int n;
    int bits;
    int nbytes;
    int k;
    start = POS_W'($urandom);
    n = $urandom_range(1, 4);
    bits = 0;
    for (k = 0; k < n; k++) begin
      widths[k] = pick_width();
      bits += effective_width(widths[k]);
    end
    nbytes = (int'(start[2:0]) + bits + 7) / 8;
    for (k = 0; k < nbytes; k++) begin
      a = start[POS_W-1:3] + ADDR_W'(k);
      write_byte(a, ($urandom_range(0, 4) == 0) ? BYTE_W'($urandom) : '0);
    end
    set_position(start);
    for (k = 0; k < n; k++) pack_field(widths[k], MAX_FIELD_WIDTH'($urandom));
    set_position(start);
    for (k = 0; k < n; k++)
      unpack_field(($urandom_range(0, 9) == 0) ? pick_width() : widths[k]);
    if ($urandom_range(0, 3) == 0) read_byte(start[POS_W-1:3]);
  endtask

  task automatic test_random_traffic();
    int burst;
    int k;
    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 3) != 0) begin
        run_roundtrip();
      end else begin
        burst = $urandom_range(1, 6);
        for (k = 0; k < burst; k++) begin
          if ($urandom_range(0, 19) == 0)
            send_item(random_item(KIND_LAST - KIND_W'($urandom_range(0, 2))));
          else
            send_item(random_item(KIND_W'($urandom_range(KIND_PACK, KIND_RDBYTE))));
        end
      end
    end
    quiet = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int expv, input int actv);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at cycle %0d: expected %0h, got %0h", what, cycles, expv, actv);
  endtask

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 0, int'(read_value_o));
      end else begin
        if (pending_results[0].read_value !== read_value_o)
          report_mismatch("read_value", pending_results[0].read_value, read_value_o);
        if (pending_results[0].bit_position !== bit_position_o)
          report_mismatch("bit_position", pending_results[0].bit_position, bit_position_o);
        void'(pending_results.pop_front());
      end
    end
  end

  // Outside quiet phases, the receiver alternates ready stretches with stalls of random length.
  initial begin
    wait (rst_n);
    @(posedge clk_i);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        int stall;
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("FAIL gray_bit_field_packer");
      $finish;
    end
  end

  initial begin
    foreach (store_image[i]) store_image[i] = '0;
    cursor_image = '0;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_byte_access();
    test_field_extremes();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS gray_bit_field_packer");
    end else begin
      $display("FAIL gray_bit_field_packer");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/gfp_pkg.sv
rtl/gfp_ram.sv
rtl/gfp_datapath.sv
rtl/gfp_ctrl.sv
rtl/gray_bit_field_packer.sv
tb/testbench.sv
